FILE: rtl/tiled_dxt1_block_decoder_macros.svh
// assertion helpers shared by the decoder modules
// every use assumes the enclosing module has clk and rst_n
`ifndef TILED_DXT1_BLOCK_DECODER_MACROS_SVH
`define TILED_DXT1_BLOCK_DECODER_MACROS_SVH

// same-cycle implication
`define TD1_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TD1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/td1_pkg.sv
package td1_pkg;

    localparam int MAX_DIM_DEF  = 1024;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int DIM_RESET    = 8;
    localparam int TILE_W       = 10;
    localparam int COORD_W      = TILE_W + 3;
    localparam int OUT_COORD_W  = 10;
    localparam int CH_W         = 8;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 48;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PIX_PER_BLK  = 16;
    localparam int CNT_W        = $clog2(PIX_PER_BLK);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    // red in the low byte, then green, then blue
    typedef logic [3*CH_W-1:0] rgb_t;

    typedef struct packed {
        rgb_t [3:0]             pal;
        logic [31:0]            idx_word;
        logic [COORD_W-1:0]     base_x;
        logic [COORD_W-1:0]     base_y;
        logic [CFG_W-1:0]       eff_w;
        logic [CFG_W-1:0]       eff_h;
    } blk_rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

FILE: rtl/td1_front.sv
module td1_front #(
    parameter int MAX_DIM = td1_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [td1_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [td1_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [td1_pkg::IN_DATA_W-1:0] s_tdata,
    input  td1_pkg::q_stat_t              stat,
    output logic                          push,
    output td1_pkg::blk_rec_t             push_rec
);
    import td1_pkg::*;

    localparam int DIV3_RECIP = 683;
    localparam int DIV3_SHIFT = 11;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [TILE_W-1:0] tile_col_reg;
    logic [TILE_W-1:0] tile_row_reg;
    logic [1:0]        sub_reg;
    logic [TILE_W-1:0] tile_col_next;
    logic [TILE_W-1:0] tile_row_next;
    logic [1:0]        sub_next;
    logic [TILE_W-1:0] col_inc;
    logic [TILE_W-1:0] row_inc;
    logic [CFG_W-1:0]  eff_w;
    logic [CFG_W-1:0]  eff_h;
    logic [15:0]       ep_a;
    logic [15:0]       ep_b;
    rgb_t              col_a;
    rgb_t              col_b;
    rgb_t              pal2;
    rgb_t              pal3;

    function automatic rgb_t expand565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {b, b[4:2], g, g[5:4], r, r[4:2]};
    endfunction

    // floor(n/3) for n below 768 by reciprocal multiply
    function automatic logic [CH_W-1:0] div3(input logic [9:0] n);
        logic [20:0] p;
        p = 21'(n) * 21'(DIV3_RECIP);
        return p[DIV3_SHIFT +: CH_W];
    endfunction

    assign eff_w = (32'(width_reg) > MAX_DIM) ? CFG_W'(MAX_DIM) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_DIM) ? CFG_W'(MAX_DIM) : height_reg;

    assign ep_a  = s_tdata[15:0];
    assign ep_b  = s_tdata[31:16];
    assign col_a = expand565(ep_a);
    assign col_b = expand565(ep_b);

    always_comb
    begin
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [9:0]      s_2a_b;
        logic [9:0]      s_a_2b;
        logic [CH_W:0]   s_ab;
        pal2 = '0;
        pal3 = '0;
        for (int k = 0; k < 3; k++)
        begin
            a      = col_a[k*CH_W +: CH_W];
            b      = col_b[k*CH_W +: CH_W];
            s_2a_b = {1'b0, a, 1'b0} + {2'b00, b};
            s_a_2b = {2'b00, a} + {1'b0, b, 1'b0};
            s_ab   = {1'b0, a} + {1'b0, b};
            if (ep_a > ep_b)
            begin
                pal2[k*CH_W +: CH_W] = div3(s_2a_b);
                pal3[k*CH_W +: CH_W] = div3(s_a_2b);
            end
            else
            begin
                pal2[k*CH_W +: CH_W] = s_ab[CH_W:1];
                pal3[k*CH_W +: CH_W] = '0;
            end
        end
    end

    assign s_tready = !stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_rec.pal      = {pal3, pal2, col_b, col_a};
        push_rec.idx_word = s_tdata[63:32];
        push_rec.base_x   = {tile_col_reg, sub_reg[0], 2'b00};
        push_rec.base_y   = {tile_row_reg, sub_reg[1], 2'b00};
        push_rec.eff_w    = eff_w;
        push_rec.eff_h    = eff_h;
    end

    // tile walk: four sub-blocks, then next tile, wrapping at the image edge
    always_comb
    begin
        sub_next      = sub_reg + 2'd1;
        tile_col_next = tile_col_reg;
        tile_row_next = tile_row_reg;
        col_inc       = tile_col_reg + 1'b1;
        row_inc       = tile_row_reg + 1'b1;
        if (sub_reg == 2'd3)
        begin
            tile_col_next = col_inc;
            if ({col_inc, 3'b000} >= COORD_W'(eff_w))
            begin
                tile_col_next = '0;
                tile_row_next = row_inc;
                if ({row_inc, 3'b000} >= COORD_W'(eff_h))
                begin
                    tile_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(DIM_RESET);
            height_reg   <= CFG_W'(DIM_RESET);
            tile_col_reg <= '0;
            tile_row_reg <= '0;
            sub_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (push)
            begin
                tile_col_reg <= tile_col_next;
                tile_row_reg <= tile_row_next;
                sub_reg      <= sub_next;
            end
        end
    end

endmodule

FILE: rtl/td1_queue.sv
`include "tiled_dxt1_block_decoder_macros.svh"

module td1_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  td1_pkg::blk_rec_t push_rec,
    input  logic              pop,
    output td1_pkg::blk_rec_t head,
    output td1_pkg::q_stat_t  stat
);
    import td1_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    blk_rec_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `TD1_ASSERT_IMPLIES(a_no_push_full, push, !stat.full,
        "block pushed into a full queue")
    `TD1_ASSERT_NEXT(a_fill_count, do_push && !do_pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")
    `TD1_ASSERT_IMPLIES(a_count_range, 1'b1, count_reg <= COUNT_W'(QUEUE_DEPTH),
        "queue count out of range")

endmodule

FILE: rtl/td1_back.sv
`include "tiled_dxt1_block_decoder_macros.svh"

module td1_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  td1_pkg::blk_rec_t              head,
    input  td1_pkg::q_stat_t               stat,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [td1_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import td1_pkg::*;

    localparam int PAD_W = OUT_DATA_W - 3*CH_W - 2*OUT_COORD_W;

    logic [CNT_W-1:0]       cnt_reg;
    logic                   out_valid_reg;
    rgb_t                   color_reg;
    logic [OUT_COORD_W-1:0] x_reg;
    logic [OUT_COORD_W-1:0] y_reg;
    logic                   inside_reg;
    logic                   last_reg;
    logic                   load;
    logic                   is_last;
    logic [1:0]             pal_idx;
    logic [COORD_W-1:0]     px;
    logic [COORD_W-1:0]     py;
    logic                   in_image;

    // output register loads a queued pixel when empty or being drained
    assign load    = !stat.empty && (!out_valid_reg || m_tready);
    assign is_last = (cnt_reg == CNT_W'(PIX_PER_BLK - 1));
    assign pop     = load && is_last;

    // first pixel sits in the top two index bits
    assign pal_idx  = head.idx_word[{~cnt_reg, 1'b0} +: 2];
    assign px       = head.base_x + COORD_W'(cnt_reg[1:0]);
    assign py       = head.base_y + COORD_W'(cnt_reg[3:2]);
    assign in_image = (px < COORD_W'(head.eff_w)) && (py < COORD_W'(head.eff_h));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            color_reg  <= head.pal[pal_idx];
            x_reg      <= px[OUT_COORD_W-1:0];
            y_reg      <= py[OUT_COORD_W-1:0];
            inside_reg <= in_image;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, y_reg, x_reg, color_reg};
    assign m_tuser  = inside_reg;
    assign m_tlast  = last_reg;

    `TD1_ASSERT_NEXT(a_last_marked, pop, m_tvalid && m_tlast,
        "sixteenth pixel not flagged last")
    `TD1_ASSERT_IMPLIES(a_block_held, cnt_reg != '0, !stat.empty,
        "block left the queue mid-stream")
    `TD1_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "pixel changed while stalled")

endmodule

FILE: rtl/tiled_dxt1_block_decoder.sv
// one compressed block in, sixteen pixels out at one pixel per cycle while m_tready holds
// first pixel passes through the queue entry and then the output register before m_tvalid
// sustained block rate is set by the single pixel output register
// a two-block queue lets the next block transfer while pixels still drain
// reset: width and height go to 8, tile position to zero, queue empty; no clearing pass
module tiled_dxt1_block_decoder #(
    parameter int MAX_DIM = td1_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [td1_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [td1_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // endpoint_a [15:0], endpoint_b [31:16], index_word [63:32]
    input  logic [td1_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red [7:0], green [15:8], blue [23:16], pixel_x [33:24], pixel_y [43:34], zero pad
    output logic [td1_pkg::OUT_DATA_W-1:0] m_tdata,
    // inside_res [0]
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import td1_pkg::*;

    blk_rec_t push_rec;
    blk_rec_t head;
    q_stat_t  stat;
    logic     push;
    logic     pop;

    td1_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .push     (push),
        .push_rec (push_rec)
    );

    td1_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    td1_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

FILE: bench/tb_tiled_dxt1_block_decoder.sv
`timescale 1ns / 100ps

module tb_tiled_dxt1_block_decoder;

    import td1_pkg::*;

    localparam int DIM_CAP      = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 250;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic       inside_res;
        logic       last_pixel;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // predictor copy of registers and tile walk position
    logic [10:0] image_w_cfg;
    logic [10:0] image_h_cfg;
    int          walk_col;
    int          walk_row;
    int          walk_quad;

    pixel_t      pending_pixels[$];
    int          fail_count;
    int unsigned cycle_count;
    int          burst_left;
    int          stall_mode;
    int          stall_mode_left;

    tiled_dxt1_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tiled_dxt1_block_decoder test failed");
            $finish;
        end
    end

    // receiver stall pattern: modes of random length
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 96);
        end
        else
        begin
            stall_mode_left = stall_mode_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycle_count % 13) < 3);
        endcase
    end

    // expected pixels of one block, then advance the tile walk
    task automatic decode_block_pixels(input logic [15:0] ea, input logic [15:0] eb,
                                       input logic [31:0] iw);
        int     pal[4][3];
        int     w;
        int     h;
        int     bx;
        int     by;
        int     px;
        int     py;
        int     sel;
        pixel_t pix;
        w = (image_w_cfg > DIM_CAP) ? DIM_CAP : image_w_cfg;
        h = (image_h_cfg > DIM_CAP) ? DIM_CAP : image_h_cfg;
        pal[0][0] = {ea[15:11], ea[15:13]};
        pal[0][1] = {ea[10:5], ea[10:9]};
        pal[0][2] = {ea[4:0], ea[4:2]};
        pal[1][0] = {eb[15:11], eb[15:13]};
        pal[1][1] = {eb[10:5], eb[10:9]};
        pal[1][2] = {eb[4:0], eb[4:2]};
        for (int k = 0; k < 3; k++)
        begin
            if (ea > eb)
            begin
                pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
                pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
            end
            else
            begin
                pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
                pal[3][k] = 0;
            end
        end
        bx = walk_col * 8 + (walk_quad % 2) * 4;
        by = walk_row * 8 + (walk_quad / 2) * 4;
        for (int i = 0; i < 16; i++)
        begin
            sel            = (iw >> (30 - 2 * i)) & 3;
            px             = bx + (i % 4);
            py             = by + (i / 4);
            pix.red        = 8'(pal[sel][0]);
            pix.green      = 8'(pal[sel][1]);
            pix.blue       = 8'(pal[sel][2]);
            pix.pixel_x    = px[9:0];
            pix.pixel_y    = py[9:0];
            pix.inside_res = (px < w) && (py < h);
            pix.last_pixel = (i == 15);
            pending_pixels.push_back(pix);
        end
        walk_quad = (walk_quad + 1) % 4;
        if (walk_quad == 0)
        begin
            walk_col = (walk_col + 1) % 1024;
            if (walk_col * 8 >= w)
            begin
                walk_col = 0;
                walk_row = (walk_row + 1) % 1024;
                if (walk_row * 8 >= h)
                    walk_row = 0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red        = m_tdata[7:0];
            got.green      = m_tdata[15:8];
            got.blue       = m_tdata[23:16];
            got.pixel_x    = m_tdata[33:24];
            got.pixel_y    = m_tdata[43:34];
            got.inside_res = m_tuser;
            got.last_pixel = m_tlast;
            if (pending_pixels.size() == 0)
            begin
                $error("pixel transfer with no pixel expected");
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)
                begin
                    $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
                    fail_count = fail_count + 1;
                end
                if (got.green !== want.green)
                begin
                    $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
                    fail_count = fail_count + 1;
                end
                if (got.blue !== want.blue)
                begin
                    $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
                    fail_count = fail_count + 1;
                end
                if (got.pixel_x !== want.pixel_x)
                begin
                    $error("pixel_x mismatch: expected %0d, actual %0d",
                           want.pixel_x, got.pixel_x);
                    fail_count = fail_count + 1;
                end
                if (got.pixel_y !== want.pixel_y)
                begin
                    $error("pixel_y mismatch: expected %0d, actual %0d",
                           want.pixel_y, got.pixel_y);
                    fail_count = fail_count + 1;
                end
                if (got.inside_res !== want.inside_res)
                begin
                    $error("inside_res mismatch: expected %0d, actual %0d",
                           want.inside_res, got.inside_res);
                    fail_count = fail_count + 1;
                end
                if (got.last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel mismatch: expected %0d, actual %0d",
                           want.last_pixel, got.last_pixel);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    task automatic send_block(input logic [15:0] ea, input logic [15:0] eb,
                              input logic [31:0] iw);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {iw, eb, ea};
        do
            @(posedge clk);
        while (!s_tready);
        decode_block_pixels(ea, eb, iw);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // bursts of random length, most of them after a random gap
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 10));
        end
        burst_left = burst_left - 1;
    endtask

    // stop sending until every pixel is out and the output stage is empty
    task automatic drain_decoder();
        sender_gap(1);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [10:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_WIDTH)
            image_w_cfg = value;
        else
            image_h_cfg = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_dims(input logic [10:0] w, input logic [10:0] h);
        drain_decoder();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic [10:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd1024;
            3: return 11'd2047;
            4: return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(1, 40));
        endcase
    endfunction

    // default 8x8 image: palette modes, index extremes, one full tile and its wrap
    task automatic test_palette_modes();
        send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'h8001, 16'h8000, 32'h1B1B_1B1B);
        send_block(16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_block(16'hF81F, 16'h07E0, 32'h0000_0000);
        send_block(16'h07E0, 16'hF81F, 32'hAAAA_5555);
    endtask

    // clipping with tiny, zero and oversized dimensions, plus a multi-tile walk
    task automatic test_dimension_edges();
        set_dims(11'd1, 11'd1);
        repeat (3) send_block(16'($urandom), 16'($urandom), $urandom);
        set_dims(11'd0, 11'd0);
        repeat (3) send_block(16'($urandom), 16'($urandom), $urandom);
        set_dims(11'd2047, 11'd5);
        repeat (3) send_block(16'($urandom), 16'($urandom), $urandom);
        set_dims(11'd12, 11'd20);
        repeat (8) send_block(16'($urandom), 16'($urandom), 32'h9C63_36C9);
        // width changes while the walk is partway through a tile
        set_dims(11'd1024, 11'd1024);
        repeat (2) send_block(16'h0001, 16'hFFFE, $urandom);
    endtask

    task automatic test_random_walk();
        logic [15:0] ea;
        logic [15:0] eb;
        logic [15:0] tmp;
        int          sent;
        int          phase_len;
        int          sel;
        bit          steady;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_dims(pick_dim(), pick_dim());
            phase_len = $urandom_range(10, 40);
            steady    = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                ea  = 16'($urandom);
                eb  = 16'($urandom);
                sel = $urandom_range(0, 9);
                if (sel < 4 && ea <= eb)
                begin
                    tmp = ea;
                    ea  = eb;
                    eb  = tmp;
                end
                else if (sel < 7 && sel >= 4 && ea > eb)
                begin
                    tmp = ea;
                    ea  = eb;
                    eb  = tmp;
                end
                else if (sel == 7)
                begin
                    eb = ea;
                end
                if (!steady)
                    pace_sender();
                if (n == phase_len / 2 && $urandom_range(0, 2) == 0)
                    drain_decoder();
                send_block(ea, eb, $urandom);
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WIDTH;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        image_w_cfg     = 11'd8;
        image_h_cfg     = 11'd8;
        walk_col        = 0;
        walk_row        = 0;
        walk_quad       = 0;
        fail_count      = 0;
        cycle_count     = 0;
        burst_left      = 0;
        stall_mode      = 0;
        stall_mode_left = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_palette_modes();
        test_dimension_edges();
        test_random_walk();

        drain_decoder();
        repeat (40) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            fail_count = fail_count + 1;
        end
        if (fail_count == 0)
            $display("tiled_dxt1_block_decoder test passed");
        else
            $display("tiled_dxt1_block_decoder test failed");
        $finish;
    end

endmodule
